// ----- src/ipp_pkg.sv -----
// shared types, constants and character helpers for the address text parser
`timescale 1ns / 1ps
`default_nettype none
package ipp_pkg;

  // parse phases
  typedef enum logic [2:0] {
    PH_TOP    = 3'd0,
    PH_ZERO   = 3'd1,
    PH_HEXPFX = 3'd2,
    PH_DIGITS = 3'd3,
    PH_COLON  = 3'd4,
    PH_DONE   = 3'd5,
    PH_ERROR  = 3'd6
  } phase_t;

  // number radix of the current ipv4 part
  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_OCT = 2'd1,
    RADIX_HEX = 2'd2
  } radix_t;

  localparam logic [7:0]  CH_NUL   = 8'h00;
  localparam logic [7:0]  CH_COLON = 8'h3A;
  localparam logic [7:0]  CH_DOT   = 8'h2E;
  localparam logic [7:0]  CH_LOW_X = 8'h78;
  localparam logic [7:0]  CH_UP_X  = 8'h58;
  localparam logic [16:0] VALUE_CAP = 17'h10000;
  localparam logic [4:0]  V4_PARTS  = 5'd4;
  localparam logic [4:0]  V6_GROUPS = 5'd8;

  // parser state carried between requests
  typedef struct packed {
    logic [15:0][7:0] ab;
    phase_t           phase;
    logic [16:0]      gval;
    logic [4:0]       gcount;
    logic [4:0]       ellpos;
    radix_t           radix;
    logic             any;
  } pstate_t;

  localparam pstate_t ST_RESET = '{ab: '0, phase: PH_TOP, gval: '0, gcount: '0,
                                   ellpos: '0, radix: RADIX_DEC, any: 1'b0};

  // {valid, value} of a hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      r = {1'b1, c[3:0] + 4'd9};
    return r;
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
           (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    return (c == CH_NUL) || !(c == CH_COLON || is_alnum(c));
  endfunction

  // value * base + digit, saturated
  function automatic logic [16:0] accumulate(input logic [16:0] v, input logic [4:0] base,
                                             input logic [3:0] d);
    logic [21:0] t;
    t = 22'(v) * 22'(base) + 22'(d);
    return (t > 22'(VALUE_CAP)) ? VALUE_CAP : t[16:0];
  endfunction

endpackage
`default_nettype wire

// ----- src/ipp_step.sv -----
// per-character state update for both address families
`timescale 1ns / 1ps
`default_nettype none
module ipp_step import ipp_pkg::*; (
  input  wire pstate_t    cur,
  input  wire logic       family,
  input  wire logic [7:0] character,
  output pstate_t         nxt
);

  logic [4:0] hd;
  logic       rd_ok;
  logic [4:0] base;
  logic       end_part;
  logic       start;
  phase_t     ph;

  always_comb begin
    nxt      = cur;
    hd       = hex_digit(character);
    end_part = 1'b0;
    start    = 1'b0;
    ph       = cur.phase;
    // digit check in the part's radix
    case (cur.radix)
      RADIX_DEC: begin
        rd_ok = character >= 8'h30 && character <= 8'h39;
        base  = 5'd10;
      end
      RADIX_OCT: begin
        rd_ok = character >= 8'h30 && character <= 8'h37;
        base  = 5'd8;
      end
      default: begin
        rd_ok = hd[4];
        base  = 5'd16;
      end
    endcase

    if (!family) begin
      // ipv4 parts
      case (cur.phase)
        PH_DONE, PH_ERROR: ;
        PH_ZERO: begin
          if (character == CH_LOW_X || character == CH_UP_X) begin
            nxt.phase = PH_HEXPFX;
          end else if (character >= 8'h30 && character <= 8'h37) begin
            nxt.radix = RADIX_OCT;
            nxt.gval  = 17'(character[2:0]);
            nxt.phase = PH_DIGITS;
          end else begin
            end_part = 1'b1;
          end
        end
        PH_HEXPFX: begin
          if (!hd[4]) begin
            nxt.phase = PH_ERROR;
          end else begin
            nxt.radix = RADIX_HEX;
            nxt.gval  = 17'(hd[3:0]);
            nxt.phase = PH_DIGITS;
          end
        end
        PH_DIGITS: begin
          if (rd_ok) nxt.gval = accumulate(cur.gval, base, hd[3:0]);
          else end_part = 1'b1;
        end
        default: begin
          if (cur.gcount >= V4_PARTS) begin
            nxt.phase = PH_DONE;
          end else if (character == CH_NUL) begin
            nxt.phase = (cur.gcount == 5'd0) ? PH_ERROR : PH_DONE;
          end else begin
            nxt.any   = 1'b1;
            nxt.radix = RADIX_DEC;
            if (character == 8'h30) begin
              nxt.gval  = '0;
              nxt.phase = PH_ZERO;
            end else if (character >= 8'h31 && character <= 8'h39) begin
              nxt.gval  = 17'(character[3:0]);
              nxt.phase = PH_DIGITS;
            end else begin
              nxt.phase = PH_ERROR;
            end
          end
        end
      endcase
      // close a part
      if (end_part) begin
        if ((character != CH_DOT && character != CH_NUL) || cur.gval > 17'd255 ||
            cur.gcount >= V4_PARTS) begin
          nxt.phase = PH_ERROR;
        end else begin
          nxt.ab[cur.gcount[1:0]] = cur.gval[7:0];
          nxt.gcount = cur.gcount + 5'd1;
          nxt.phase  = (character == CH_NUL || cur.gcount == 5'd3) ? PH_DONE : PH_TOP;
        end
      end
    end else begin
      // ipv6 groups
      if (ph == PH_ZERO || ph == PH_HEXPFX) ph = PH_DIGITS;
      if (ph == PH_DONE || ph == PH_ERROR) begin
        nxt.phase = ph;
      end else if (ph == PH_DIGITS) begin
        nxt.phase = ph;
        if (hd[4]) begin
          nxt.gval = accumulate(cur.gval, 5'd16, hd[3:0]);
        end else if (cur.gval > 17'hFFFF) begin
          nxt.phase = PH_ERROR;
        end else if (character == CH_COLON || is_delim(character)) begin
          if (cur.gcount >= V6_GROUPS) begin
            nxt.phase = PH_ERROR;
          end else begin
            nxt.ab[{cur.gcount[2:0], 1'b0}] = cur.gval[15:8];
            nxt.ab[{cur.gcount[2:0], 1'b1}] = cur.gval[7:0];
            nxt.gcount = cur.gcount + 5'd1;
            nxt.phase  = (character == CH_COLON) ? PH_COLON : PH_DONE;
          end
        end else begin
          nxt.phase = PH_ERROR;
        end
      end else if (ph == PH_COLON && character == CH_COLON) begin
        if (cur.ellpos != 5'd0) begin
          nxt.phase = PH_ERROR;
        end else begin
          nxt.phase  = PH_TOP;
          nxt.ellpos = {cur.gcount[3:0], 1'b0};
        end
      end else begin
        start = 1'b1;
      end
      // start of a group
      if (start) begin
        if (cur.gcount >= V6_GROUPS) begin
          nxt.phase = is_delim(character) ? PH_DONE : PH_ERROR;
        end else if (hd[4]) begin
          nxt.any   = 1'b1;
          nxt.gval  = 17'(hd[3:0]);
          nxt.phase = PH_DIGITS;
        end else if (character == CH_COLON) begin
          nxt.any = 1'b1;
          nxt.ab[{cur.gcount[2:0], 1'b0}] = 8'h00;
          nxt.ab[{cur.gcount[2:0], 1'b1}] = 8'h00;
          nxt.gcount = cur.gcount + 5'd1;
          nxt.phase  = PH_COLON;
        end else begin
          nxt.phase = (cur.any && is_delim(character)) ? PH_DONE : PH_ERROR;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/ipp_format.sv -----
// final address assembly: ipv6 ellipsis alignment and ipv4 shorthand
`timescale 1ns / 1ps
`default_nettype none
module ipp_format import ipp_pkg::*; (
  input  wire pstate_t     st,
  input  wire logic        family,
  output logic             status,
  output logic [63:0]      addr_high,
  output logic [63:0]      addr_low
);

  logic [4:0]       n;
  logic [4:0]       ell;
  logic [4:0]       gap;
  logic [5:0]       ell_end;
  logic [4:0]       idx;
  logic [15:0][7:0] a;
  logic [3:0][7:0]  b;

  always_comb begin
    status    = (st.phase != PH_DONE);
    addr_high = '0;
    addr_low  = '0;
    n         = {st.gcount[3:0], 1'b0};
    ell       = (st.ellpos > n) ? n : st.ellpos;
    gap       = 5'd16 - n;
    ell_end   = 6'(ell) + 6'(gap);
    a         = st.ab;
    idx       = '0;
    // right-align groups behind the ellipsis
    if (st.gcount < V6_GROUPS) begin
      for (int k = 0; k < 16; k++) begin
        idx = 5'(k) - gap;
        if (5'(k) < ell) a[k] = st.ab[k];
        else if (6'(k) < ell_end) a[k] = 8'h00;
        else a[k] = st.ab[idx[3:0]];
      end
    end
    // ipv4 class shorthand
    for (int k = 0; k < 4; k++) b[k] = st.ab[k];
    if (st.ab[0][7:6] <= 2'd1) begin
      if (st.gcount == 5'd3) begin
        b[3] = st.ab[2];
        b[2] = st.ab[1];
        b[1] = 8'h00;
      end else if (st.gcount == 5'd2) begin
        b[3] = st.ab[1];
        b[1] = 8'h00;
      end
    end else if (st.ab[0][7:6] == 2'd2 && st.gcount == 5'd3) begin
      b[3] = st.ab[2];
      b[2] = 8'h00;
    end
    if (!status) begin
      if (family) begin
        for (int k = 0; k < 8; k++) begin
          addr_high[63 - 8*k -: 8] = a[k];
          addr_low[63 - 8*k -: 8]  = a[k + 8];
        end
      end else begin
        addr_low = {32'h0, b[0], b[1], b[2], b[3]};
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/ip_address_text_parser.sv -----
// top level of the streaming ipv4/ipv6 address text parser
// Usage:
//   Input channel (in_valid/in_ready) carries one character per request with
//   a family flag: 0 dotted ipv4 text, 1 colon ipv6 text. A NUL character
//   ends the string.
//   Output channel (out_valid/out_ready) carries one result per string,
//   produced for the NUL request: out_status (0 ok, 1 error) and the
//   128-bit address as out_addr_high / out_addr_low (zero on error).
//   The result is valid in the cycle after the NUL is accepted.
//   Throughput: one character per cycle while in_ready is high; state update
//   and address assembly sit between the parser state and result registers.
//   A full result register that is not being drained holds in_ready low;
//   characters keep flowing while the result waits only when out_ready is high.
//   Reset (rst_n low, synchronous) clears the parser state and drops
//   out_valid. After each NUL the parser restarts for the next string.
`timescale 1ns / 1ps
`default_nettype none
module ip_address_text_parser import ipp_pkg::*; (
  input  wire  logic        clk,
  input  wire  logic        rst_n,
  input  wire  logic        in_valid,
  output logic              in_ready,
  input  wire  logic        in_family,
  input  wire  logic [7:0]  in_character,
  output logic              out_valid,
  input  wire  logic        out_ready,
  output logic              out_status,
  output logic [63:0]       out_addr_high,
  output logic [63:0]       out_addr_low
);

  pstate_t     st_r;
  pstate_t     st_nxt;
  logic        out_valid_r;
  logic        status_r;
  logic [63:0] high_r;
  logic [63:0] low_r;
  logic        f_status;
  logic [63:0] f_high;
  logic [63:0] f_low;
  logic        acc;

  assign in_ready = !out_valid_r || out_ready;
  assign acc      = in_valid && in_ready;

  // character step
  ipp_step u_step (
    .cur       (st_r),
    .family    (in_family),
    .character (in_character),
    .nxt       (st_nxt)
  );

  // address assembly on the ending character
  ipp_format u_format (
    .st        (st_nxt),
    .family    (in_family),
    .status    (f_status),
    .addr_high (f_high),
    .addr_low  (f_low)
  );

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_RESET;
    end else if (acc) begin
      st_r <= (in_character == CH_NUL) ? ST_RESET : st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc && in_character == CH_NUL) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && in_character == CH_NUL) begin
      status_r <= f_status;
      high_r   <= f_high;
      low_r    <= f_low;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_addr_high = high_r;
  assign out_addr_low  = low_r;

`ifndef SYNTH
  // an error result carries a zero address
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_addr_high == 64'h0 && out_addr_low == 64'h0)
    else $error("error result with nonzero address");

  // a NUL request always yields a result next cycle
  a_nul_result: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_character == CH_NUL |=> out_valid)
    else $error("missing result after NUL");

  // a plain character never creates a result
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_character != CH_NUL && (!out_valid || out_ready) |=> !out_valid)
    else $error("result without NUL");

  // group count stays within eight groups
  a_gcount: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.gcount <= V6_GROUPS)
    else $error("group count overflow");
`endif

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// testbench for the streaming ipv4/ipv6 address text parser
`timescale 1ns / 1ps
module testbench;
  import ipp_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_family;
  logic [7:0]  in_character;
  logic        out_valid;
  logic        out_ready;
  logic        out_status;
  logic [63:0] out_addr_high;
  logic [63:0] out_addr_low;

  ip_address_text_parser u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_family(in_family), .in_character(in_character),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_addr_high(out_addr_high), .out_addr_low(out_addr_low)
  );

  typedef struct packed {
    logic        status;
    logic [63:0] hi;
    logic [63:0] lo;
  } addr_result_t;

  // predictor state
  logic [7:0]  m_bytes [16];
  phase_t      m_phase;
  logic [16:0] m_gval;
  logic [4:0]  m_gcount;
  logic [4:0]  m_ellpos;
  radix_t      m_radix;
  logic        m_any;

  addr_result_t parsed_q[$];
  int          n_fail;
  int          cycle_cnt;
  bit          idle_on;
  bit          long_hold;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk);
      cycle_cnt++;
      if (cycle_cnt > 400000) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  function automatic int hexval(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function automatic bit alnum(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit delim(input logic [7:0] c);
    return (c == CH_NUL) || !(c == CH_COLON || alnum(c));
  endfunction

  task automatic clear_parser();
    for (int k = 0; k < 16; k++) m_bytes[k] = 8'h0;
    m_phase = PH_TOP; m_gval = '0; m_gcount = '0; m_ellpos = '0;
    m_radix = RADIX_DEC; m_any = 1'b0;
  endtask

  task automatic grow_value(input int d, input int base);
    int t;
    t = m_gval * base + d;
    m_gval = (t > 'h10000) ? VALUE_CAP : 17'(t);
  endtask

  task automatic v4_close(input logic [7:0] c);
    if ((c != CH_DOT && c != CH_NUL) || m_gval > 255 || m_gcount >= 4) begin
      m_phase = PH_ERROR;
      return;
    end
    m_bytes[m_gcount[1:0]] = m_gval[7:0];
    m_gcount++;
    m_phase = (c == CH_NUL || m_gcount == 4) ? PH_DONE : PH_TOP;
  endtask

  task automatic v4_char(input logic [7:0] c);
    int d;
    case (m_phase)
      PH_DONE, PH_ERROR: ;
      PH_ZERO: begin
        if (c == CH_LOW_X || c == CH_UP_X) m_phase = PH_HEXPFX;
        else if (c >= "0" && c <= "7") begin
          m_radix = RADIX_OCT; m_gval = 17'(c - "0"); m_phase = PH_DIGITS;
        end else v4_close(c);
      end
      PH_HEXPFX: begin
        d = hexval(c);
        if (d < 0) m_phase = PH_ERROR;
        else begin
          m_radix = RADIX_HEX; m_gval = 17'(d); m_phase = PH_DIGITS;
        end
      end
      PH_DIGITS: begin
        if (m_radix == RADIX_DEC) d = (c >= "0" && c <= "9") ? c - "0" : -1;
        else if (m_radix == RADIX_OCT) d = (c >= "0" && c <= "7") ? c - "0" : -1;
        else d = hexval(c);
        if (d >= 0) grow_value(d, m_radix == RADIX_DEC ? 10 : (m_radix == RADIX_OCT ? 8 : 16));
        else v4_close(c);
      end
      default: begin
        if (m_gcount >= 4) m_phase = PH_DONE;
        else if (c == CH_NUL) m_phase = (m_gcount == 0) ? PH_ERROR : PH_DONE;
        else begin
          m_any = 1'b1; m_radix = RADIX_DEC;
          if (c == "0") begin
            m_gval = '0; m_phase = PH_ZERO;
          end else if (c >= "1" && c <= "9") begin
            m_gval = 17'(c - "0"); m_phase = PH_DIGITS;
          end else m_phase = PH_ERROR;
        end
      end
    endcase
  endtask

  function automatic bit v6_put(input logic [15:0] v);
    if (m_gcount >= 8) begin
      m_phase = PH_ERROR;
      return 0;
    end
    m_bytes[(m_gcount * 2) % 16] = v[15:8];
    m_bytes[(m_gcount * 2 + 1) % 16] = v[7:0];
    m_gcount++;
    return 1;
  endfunction

  task automatic v6_char(input logic [7:0] c);
    int d;
    if (m_phase == PH_DONE || m_phase == PH_ERROR) return;
    if (m_phase == PH_ZERO || m_phase == PH_HEXPFX) m_phase = PH_DIGITS;
    if (m_phase == PH_DIGITS) begin
      d = hexval(c);
      if (d >= 0) grow_value(d, 16);
      else if (m_gval > 'hFFFF) m_phase = PH_ERROR;
      else if (c == CH_COLON) begin
        if (v6_put(m_gval[15:0])) m_phase = PH_COLON;
      end else if (delim(c)) begin
        if (v6_put(m_gval[15:0])) m_phase = PH_DONE;
      end else m_phase = PH_ERROR;
      return;
    end
    if (m_phase == PH_COLON) begin
      m_phase = PH_TOP;
      if (c == CH_COLON) begin
        if (m_ellpos != 0) m_phase = PH_ERROR;
        else m_ellpos = 5'((m_gcount * 2) % 32);
        return;
      end
    end
    // start of group
    if (m_gcount >= 8) begin
      m_phase = delim(c) ? PH_DONE : PH_ERROR;
      return;
    end
    d = hexval(c);
    if (d >= 0) begin
      m_any = 1'b1; m_gval = 17'(d); m_phase = PH_DIGITS;
    end else if (c == CH_COLON) begin
      m_any = 1'b1;
      if (v6_put(16'h0)) m_phase = PH_COLON;
    end else m_phase = (m_any && delim(c)) ? PH_DONE : PH_ERROR;
  endtask

  // advance the predictor by one request, queueing a result on nul
  task automatic predict_char(input logic fam, input logic [7:0] c);
    addr_result_t r;
    logic [7:0] a [16];
    int n, ell, gap;
    if (fam) v6_char(c);
    else v4_char(c);
    if (c != CH_NUL) return;
    r = '0;
    if (m_phase == PH_DONE) begin
      if (fam) begin
        n = (m_gcount > 8) ? 16 : m_gcount * 2;
        ell = (m_ellpos > n) ? n : m_ellpos;
        gap = 16 - n;
        for (int k = 0; k < 16; k++) begin
          if (n >= 16 || k < ell) a[k] = m_bytes[k];
          else if (k < ell + gap) a[k] = 8'h0;
          else a[k] = m_bytes[(k - gap) % 16];
        end
        for (int k = 0; k < 8; k++) begin
          r.hi = {r.hi[55:0], a[k]};
          r.lo = {r.lo[55:0], a[k + 8]};
        end
      end else begin
        for (int k = 0; k < 4; k++) a[k] = m_bytes[k];
        if (a[0][7:6] <= 2'd1) begin
          if (m_gcount == 3) begin
            a[3] = a[2]; a[2] = a[1]; a[1] = 8'h0;
          end else if (m_gcount == 2) begin
            a[3] = a[1]; a[1] = 8'h0;
          end
        end else if (a[0][7:6] == 2'd2 && m_gcount == 3) begin
          a[3] = a[2]; a[2] = 8'h0;
        end
        r.lo = {32'h0, a[0], a[1], a[2], a[3]};
      end
    end else r.status = 1'b1;
    parsed_q.push_back(r);
    clear_parser();
  endtask

  // send one character request; valid stays up into the next request
  task automatic send_char(input logic fam, input logic [7:0] c);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_family <= fam;
    in_character <= c;
    do @(posedge clk); while (!in_ready);
    predict_char(fam, c);
    @(negedge clk);
  endtask

  task automatic send_text(input logic fam, input string s);
    for (int i = 0; i < s.len(); i++) send_char(fam, s[i]);
    send_char(fam, CH_NUL);
  endtask

  // result checker
  always @(posedge clk) begin
    addr_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (parsed_q.size() == 0) begin
        $error("unexpected result status=%0d", out_status);
        n_fail++;
      end else begin
        e = parsed_q.pop_front();
        if (out_status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_status); n_fail++;
        end
        if (out_addr_high !== e.hi) begin
          $error("addr_high exp %h got %h", e.hi, out_addr_high); n_fail++;
        end
        if (out_addr_low !== e.lo) begin
          $error("addr_low exp %h got %h", e.lo, out_addr_low); n_fail++;
        end
      end
    end
  end

  // receiver stalls
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (60) @(negedge clk);
        long_hold = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8) - 1) @(negedge clk);
      end else out_ready <= 1'b1;
    end
  end

  function automatic logic [7:0] pick_char(input logic fam);
    case ($urandom_range(0, 9))
      0, 1, 2: return 8'("0" + $urandom_range(0, 9));
      3: return fam ? CH_COLON : CH_DOT;
      4: return 8'("a" + $urandom_range(0, 5));
      5: return 8'("A" + $urandom_range(0, 5));
      6: return fam ? "0" : CH_LOW_X;
      7: return fam ? CH_COLON : "0";
      8: return CH_DOT;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  task automatic test_ipv4_directed();
    send_text(1'b0, "");
    send_text(1'b0, "255.255.255.255");
    send_text(1'b0, "0.0.0.0");
    send_text(1'b0, "10.1");
    send_text(1'b0, "10.1.2");
    send_text(1'b0, "172.16.5");
    send_text(1'b0, "192.1.2");
    send_text(1'b0, "0x7f.010.0X1.1");
    send_text(1'b0, "1.2.3.");
    send_text(1'b0, "1.2.3.4.zz");
    send_text(1'b0, "256.1.1.1");
    send_text(1'b0, "1..2");
    send_text(1'b0, " 1.2");
    send_text(1'b0, "0x");
    send_text(1'b0, "99999999");
    send_text(1'b0, "1.2\377");
  endtask

  task automatic test_ipv6_directed();
    send_text(1'b1, "::");
    send_text(1'b1, "1::2");
    send_text(1'b1, "ffff:FFFF:0:1:2:3:4:5");
    send_text(1'b1, "1:2:3:4:5:6:7:8:9");
    send_text(1'b1, "1:2:3:4:5:6:7:8 junk");
    send_text(1'b1, "1::2::3");
    send_text(1'b1, "12345::");
    send_text(1'b1, "1x::");
    send_text(1'b1, "fe80::1%eth0");
    send_text(1'b1, ":1");
    send_text(1'b1, "");
    send_text(1'b1, "a:\200");
  endtask

  // same string with the family flipped mid-way
  task automatic test_family_switch();
    send_char(1'b0, "1"); send_char(1'b1, ":"); send_char(1'b0, "2"); send_char(1'b1, CH_NUL);
    send_char(1'b1, "a"); send_char(1'b1, ":"); send_char(1'b0, "3"); send_char(1'b0, CH_NUL);
  endtask

  // mostly well-formed addresses with random content, plus noise
  task automatic test_random(input int n_chars);
    int sent;
    logic fam;
    int len;
    sent = 0;
    while (sent < n_chars) begin
      fam = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 3) != 0) begin
        len = fam ? $urandom_range(1, 9) : $urandom_range(1, 5);
        for (int g = 0; g < len; g++) begin
          if (g > 0) begin
            send_char(fam, fam ? CH_COLON : CH_DOT); sent++;
            if (fam && $urandom_range(0, 7) == 0) begin
              send_char(fam, CH_COLON); sent++;
            end
          end
          if (fam) begin
            for (int d = 0; d < $urandom_range(1, 4); d++) begin
              send_char(fam, 8'("0" + $urandom_range(0, 9))); sent++;
            end
          end else case ($urandom_range(0, 3))
            0: begin
              send_char(1'b0, "0"); send_char(1'b0, CH_LOW_X);
              send_char(1'b0, 8'("a" + $urandom_range(0, 5))); sent += 3;
            end
            1: begin
              send_char(1'b0, "0"); send_char(1'b0, 8'("0" + $urandom_range(0, 7)));
              sent += 2;
            end
            default: begin
              send_char(1'b0, 8'("1" + $urandom_range(0, 8)));
              if ($urandom_range(0, 1)) send_char(1'b0, 8'("0" + $urandom_range(0, 9)));
              sent += 2;
            end
          endcase
        end
        if ($urandom_range(0, 9) == 0) begin
          send_char(fam, 8'($urandom_range(1, 255))); sent++;
        end
      end else begin
        len = $urandom_range(0, 10);
        for (int i = 0; i < len; i++) begin
          send_char(fam, pick_char(fam)); sent++;
        end
      end
      send_char(fam, CH_NUL); sent++;
    end
  endtask

  // receiver held off while strings keep coming
  task automatic test_backpressure();
    long_hold = 1'b1;
    for (int i = 0; i < 6; i++) send_text(1'($urandom_range(0, 1)), "1::");
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_family = 1'b0;
    in_character = 8'h0;
    idle_on = 1'b1;
    long_hold = 1'b0;
    n_fail = 0;
    clear_parser();
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    test_ipv4_directed();
    test_ipv6_directed();
    test_family_switch();
    test_backpressure();
    test_random(730);
    idle_on = 1'b0;
    test_random(150);
    in_valid <= 1'b0;
    while (parsed_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (n_fail == 0 && parsed_q.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
